// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl files that check themselves
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is high
`define OLE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same check, also active during reset
`define OLE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/olist_pkg.sv =====
// shared types, codes and sizes of the ordered list engine
// no dependencies
`default_nettype none

package olist_pkg;

  localparam int DATA_W       = 32;
  localparam int ACT_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int S_DATA_W     = ((ACT_W + DATA_W + 7) / 8) * 8;
  localparam int M_DATA_W     = ((STATUS_W + 1 + COUNT_W + 7) / 8) * 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd6;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  // command class set by the front part
  localparam logic [1:0] KIND_INS  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_FIND = 2'd2;
  localparam logic [1:0] KIND_CLR  = 2'd3;

  typedef struct packed {
    logic [1:0]              kind;
    logic [ACT_W-1:0]        act;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic                found;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic logic [1:0] classify(input logic [ACT_W-1:0] act);
    logic [1:0] k;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: k = KIND_INS;
      ACT_POP_FRONT, ACT_POP_BACK:               k = KIND_DEL;
      ACT_REMOVE, ACT_SEARCH:                    k = KIND_FIND;
      default:                                   k = KIND_CLR;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/olist_front.sv =====
// front part: accepts request transactions, classifies them, queues commands
// depends on olist_pkg
`default_nettype none

module olist_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // action [2:0], value [34:3], zero pad above
  input  wire logic [olist_pkg::S_DATA_W-1:0] s_tdata,
  output logic                               q_valid,
  input  wire logic                          q_pop,
  output olist_pkg::cmd_t                    q_cmd
);
  import olist_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  cmd_t              in_cmd;
  logic              push;
  logic              pop;

  assign in_cmd.act   = s_tdata[ACT_W-1:0];
  assign in_cmd.value = s_tdata[ACT_W+DATA_W-1:ACT_W];
  assign in_cmd.kind  = classify(s_tdata[ACT_W-1:0]);

  assign s_tready = (fill != FILL_W'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;
  assign q_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/olist_cells.sv =====
// back part: row of value cells that compare in parallel and shift in one step
// depends on olist_pkg
`default_nettype none

module olist_cells #(
  parameter int CAPACITY = olist_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire olist_pkg::cmd_t q_cmd,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output olist_pkg::result_t   res,
  output logic [CNT_W-1:0]     held
);
  import olist_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  logic [1:0]                state;
  logic [1:0]                state_next;
  cmd_t                      cmd;
  logic signed [DATA_W-1:0]  cells [CAPACITY];
  logic [CAPACITY-1:0]       lt_r;
  logic [CAPACITY-1:0]       eq_r;

  logic                      exe_fire;
  logic [CAPACITY-1:0]       valid_v;
  logic [CAPACITY-1:0]       tail_v;
  logic [CAPACITY-1:0]       at_held_v;
  logic [CAPACITY-1:0]       cand;
  logic [CAPACITY-1:0]       ge_pos;
  logic [CAPACITY-1:0]       at_pos;
  logic                      empty;
  logic                      full;
  logic                      gt_tail;
  logic                      do_ins;
  logic                      do_drop;
  logic [CNT_W-1:0]          held_next;
  logic [STATUS_W-1:0]       status;
  logic                      found;

  assign exe_fire = (state == S_EXE) && (!res_valid || res_ready);
  assign q_pop    = q_valid && ((state == S_IDLE) || exe_fire);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_pop) state_next = S_CMP;
      S_CMP:   state_next = S_EXE;
      S_EXE:   if (exe_fire) state_next = q_pop ? S_CMP : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_v[i]   = CNT_W'(i) < held;
      tail_v[i]    = held == CNT_W'(i + 1);
      at_held_v[i] = held == CNT_W'(i);
    end
  end

  assign empty   = (held == '0);
  assign full    = (held == CNT_W'(CAPACITY));
  // value above the tail: the tail cell is below the value
  assign gt_tail = |(lt_r & tail_v);

  always_comb begin
    cand    = '0;
    do_ins  = 1'b0;
    do_drop = 1'b0;
    status  = ST_DONE;
    found   = 1'b0;
    held_next = held;
    case (cmd.kind)
      KIND_INS: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          held_next = held + 1'b1;
          // a value strictly below the head goes first, even when above the tail
          if (cmd.act == ACT_PUSH_FRONT || empty ||
              (cmd.act == ACT_INSERT && !lt_r[0] && !eq_r[0])) begin
            cand[0] = 1'b1;
          end else if (cmd.act == ACT_PUSH_BACK || gt_tail) begin
            cand = at_held_v;
          end else begin
            // first cell not below the value
            cand = ~lt_r & valid_v;
          end
        end
      end
      KIND_DEL: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          held_next = held - 1'b1;
          if (cmd.act == ACT_POP_FRONT) begin
            do_drop = 1'b1;
            cand[0] = 1'b1;
          end
        end
      end
      KIND_FIND: begin
        cand = eq_r & valid_v;
        if (empty) begin
          status = ST_EMPTY;
        end else if (cand == '0) begin
          status = ST_MISS;
        end else begin
          found = 1'b1;
          if (cmd.act == ACT_REMOVE) begin
            do_drop   = 1'b1;
            held_next = held - 1'b1;
          end
        end
      end
      default: held_next = '0;
    endcase
  end

  // inclusive prefix marks every cell at or after the chosen position
  always_comb begin
    ge_pos[0] = cand[0];
    for (int i = 1; i < CAPACITY; i++) begin
      ge_pos[i] = ge_pos[i-1] | cand[i];
    end
    at_pos[0] = ge_pos[0];
    for (int i = 1; i < CAPACITY; i++) begin
      at_pos[i] = ge_pos[i] & ~ge_pos[i-1];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (state == S_CMP) begin
        lt_r[i] <= cells[i] < cmd.value;
        eq_r[i] <= cells[i] == cmd.value;
      end
      if (exe_fire && do_ins) begin
        if (at_pos[i]) begin
          cells[i] <= cmd.value;
        end else if (ge_pos[i]) begin
          if (i > 0) cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end
      end else if (exe_fire && do_drop && ge_pos[i]) begin
        if (i < CAPACITY - 1) cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (exe_fire) begin
      res.status <= status;
      res.found  <= found;
      res.count  <= COUNT_W'(held_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exe_fire) begin
        held      <= held_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ordered_list_engine_core.sv =====
// ordered list engine: an accepted item passes the command queue, the command register, the compare
// registers and the result register before its result is valid on the result side
// the cells take one command at a time, with compare then shift passes, and take the next only as a result is issued
// a two-entry command queue lets the request side run ahead of a stalled result side
// reset clears the count, the queue and the result valid flag; cell contents are not reset
// top level; depends on olist_pkg, olist_front, olist_cells and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ordered_list_engine_core #(
  parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // action [2:0], value [34:3], zero pad above
  input  wire logic [olist_pkg::S_DATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // status [1:0], found [2], count [7:3]
  output logic [olist_pkg::M_DATA_W-1:0]     m_tdata
);
  import olist_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             q_valid;
  logic             q_pop;
  cmd_t             q_cmd;
  result_t          res;
  logic [CNT_W-1:0] held;

  olist_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  olist_cells #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_cells (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res),
    .held      (held)
  );

  assign m_tdata = M_DATA_W'(res);

  `OLE_ASSERT(a_held_bound, clk, rst, held <= CNT_W'(CAPACITY), "count above capacity")
  `OLE_ASSERT(a_full_at_cap, clk, rst, (m_tvalid && res.status == ST_FULL) |-> (held == CNT_W'(CAPACITY)), "full status with room left")
  `OLE_ASSERT(a_found_done, clk, rst, (m_tvalid && res.found) |-> (res.status == ST_DONE), "found with failing status")
  `OLE_ASSERT(a_count_match, clk, rst, m_tvalid |-> (res.count == COUNT_W'(held)), "reported count differs from held count")

endmodule

`default_nettype wire

// ===== tb/sv/ordered_list_engine_core_tb.sv =====
// self-checking testbench for ordered_list_engine_core: directed, fill, random and stall tests
// keeps its own model of the list and checks every result transaction in order
// depends on olist_pkg and the ordered_list_engine_core rtl
module ordered_list_engine_core_tb;
  import olist_pkg::*;

  localparam int LIST_CAP     = CAPACITY_DEF;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RES_W        = STATUS_W + 1 + COUNT_W;

  typedef struct packed {
    logic [ACT_W-1:0]         act;
    logic signed [DATA_W-1:0] val;
    result_t                  res;
  } pending_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // model of the list contents, front at index 0
  logic signed [DATA_W-1:0] list_cells [LIST_CAP];
  int                       list_len = 0;

  pending_result_t expected_results [$];
  pending_result_t want;
  result_t         got;

  int  error_count     = 0;
  int  requests_sent   = 0;
  int  results_checked = 0;
  int  full_drops      = 0;
  int  empty_hits      = 0;
  int  miss_hits       = 0;
  int  peak_len        = 0;
  int  quiet_cycles    = 0;
  int  hold_token      = 0;
  int  hold_served     = 0;
  int  hold_left       = 0;
  bit  no_idle         = 1'b0;

  ordered_list_engine_core #(.CAPACITY(LIST_CAP)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // list behavior for one request; updates the model and returns the result
  function automatic result_t predict_result(input logic [ACT_W-1:0] act,
                                             input logic signed [DATA_W-1:0] val);
    result_t r;
    int      pos;
    int      i;
    r        = '0;
    r.status = ST_DONE;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
        if (list_len >= LIST_CAP) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          // equal to head also goes to the front, through the search below, unless above the tail
          if (act == ACT_PUSH_FRONT || list_len == 0 ||
              (act == ACT_INSERT && val < list_cells[0])) begin
            pos = 0;
          end else if (act == ACT_PUSH_BACK || val > list_cells[list_len-1]) begin
            pos = list_len;
          end else begin
            pos = 0;
            while (pos < list_len && list_cells[pos] < val) pos++;
          end
          for (i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = val;
          list_len++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          pos = (act == ACT_POP_FRONT) ? 0 : list_len - 1;
          for (i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      ACT_REMOVE, ACT_SEARCH: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          pos = 0;
          while (pos < list_len && list_cells[pos] != val) pos++;
          if (pos >= list_len) begin
            r.status = ST_MISS;
            miss_hits++;
          end else begin
            r.found = 1'b1;
            if (act == ACT_REMOVE) begin
              for (i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
              list_len--;
            end
          end
        end
      end
      default: list_len = 0;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // mix of wide random, clustered small values, extremes and values already held
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4, 5, 6: v = int'($urandom_range(16)) - 8;
      7: begin
        case ($urandom_range(3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = (list_len > 0) ? list_cells[$urandom_range(list_len-1)] : $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [ACT_W-1:0] pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 15) return ACT_PUSH_FRONT;
    if (r < 30) return ACT_PUSH_BACK;
    if (r < 50) return ACT_INSERT;
    if (r < 58) return ACT_POP_FRONT;
    if (r < 66) return ACT_POP_BACK;
    if (r < 78) return ACT_REMOVE;
    if (r < 94) return ACT_SEARCH;
    return ACT_CLEAR;
  endfunction

  // one request transaction; valid stays high into the next call unless it idles
  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [DATA_W-1:0] val);
    pending_result_t entry;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W-ACT_W-DATA_W){1'b0}}, val, act};
    do @(posedge clk); while (!s_tready);
    entry.act = act;
    entry.val = val;
    entry.res = predict_result(act, val);
    expected_results.push_back(entry);
    requests_sent++;
  endtask

  task automatic test_directed_cases();
    send_request(ACT_CLEAR,      0);
    send_request(ACT_POP_FRONT,  0);
    send_request(ACT_POP_BACK,   0);
    send_request(ACT_SEARCH,     0);
    send_request(ACT_REMOVE,     0);
    send_request(ACT_INSERT,     0);
    send_request(ACT_INSERT,     32'sh7fff_ffff);
    send_request(ACT_INSERT,     32'sh8000_0000);
    send_request(ACT_INSERT,     32'sh8000_0000);
    send_request(ACT_INSERT,     -1);
    send_request(ACT_PUSH_FRONT, 5);
    send_request(ACT_PUSH_BACK,  -7);
    // contents are no longer sorted here
    send_request(ACT_INSERT,     3);
    send_request(ACT_INSERT,     5);
    send_request(ACT_SEARCH,     32'sh7fff_ffff);
    send_request(ACT_SEARCH,     12345);
    send_request(ACT_REMOVE,     12345);
    send_request(ACT_REMOVE,     0);
    send_request(ACT_POP_FRONT,  0);
    send_request(ACT_POP_BACK,   0);
    send_request(ACT_CLEAR,      0);
    send_request(ACT_SEARCH,     -1);
  endtask

  task automatic test_fill_to_capacity();
    int round;
    int k;
    for (round = 0; round < 3; round++) begin
      send_request(ACT_CLEAR, pick_value());
      while (list_len < LIST_CAP)
        send_request(ACT_PUSH_FRONT + ACT_W'($urandom_range(2)), pick_value());
      send_request(ACT_PUSH_FRONT, pick_value());
      send_request(ACT_PUSH_BACK,  pick_value());
      send_request(ACT_INSERT,     pick_value());
      send_request(ACT_SEARCH,     pick_value());
      while (list_len > 0) begin
        case ($urandom_range(2))
          0: send_request(ACT_POP_FRONT, pick_value());
          1: send_request(ACT_POP_BACK,  pick_value());
          default: send_request(ACT_REMOVE, pick_value());
        endcase
      end
      for (k = 0; k < 2; k++) send_request(ACT_POP_FRONT + ACT_W'(k), pick_value());
    end
  endtask

  task automatic test_random_mix(input int n_items);
    int i;
    for (i = 0; i < n_items; i++) begin
      // a long stretch without gaps on either side
      if (i == n_items / 3) no_idle <= 1'b1;
      if (i == n_items / 3 + 150) no_idle <= 1'b0;
      send_request(pick_action(), pick_value());
    end
  endtask

  task automatic test_output_stall(input int n_items);
    int i;
    hold_token <= hold_token + 1;
    for (i = 0; i < n_items; i++) send_request(pick_action(), pick_value());
  endtask

  // result side: random gaps, a long hold-off on request, none in the quiet stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_token) begin
      hold_served <= hold_token;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[RES_W-1:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: result with none pending, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.status !== want.res.status) begin
          $display("%0t: act %0d val %0d status expected %0d actual %0d",
                   $time, want.act, want.val, want.res.status, got.status);
          error_count++;
        end
        if (got.found !== want.res.found) begin
          $display("%0t: act %0d val %0d found expected %0d actual %0d",
                   $time, want.act, want.val, want.res.found, got.found);
          error_count++;
        end
        if (got.count !== want.res.count) begin
          $display("%0t: act %0d val %0d count expected %0d actual %0d",
                   $time, want.act, want.val, want.res.count, got.count);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles where neither side moves a transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results pending",
               $time, quiet_cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_fill_to_capacity();
    test_random_mix(760);
    test_output_stall(80);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests, %0d results checked, peak length %0d of %0d",
             requests_sent, results_checked, peak_len, LIST_CAP);
    $display("full drops %0d, empty-list hits %0d, value misses %0d, errors %0d",
             full_drops, empty_hits, miss_hits, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
